// ===== rtl/core/cht_pkg.sv =====
// Package for the convex hull trick engine: widths, codes, command, status and config types.
// Used by every module of the block but cht_ram; depends on nothing.
package cht_pkg;

  localparam int HULL_DEPTH = 1024;
  localparam int ADDR_W = $clog2(HULL_DEPTH);
  localparam int CNT_W = $clog2(HULL_DEPTH + 1);

  localparam int SLOPE_W = 32;
  localparam int ICPT_W = 48;
  localparam int X_W = 32;
  localparam int VALUE_W = 64;
  localparam int LINE_W = SLOPE_W + ICPT_W;
  localparam int DB_W = ICPT_W + 1;
  localparam int DK_W = SLOPE_W + 1;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CROSS_W = DB_W + DK_W;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_BQUERY = 3'd1;
  localparam logic [2:0] ACT_PQUERY = 3'd2;
  localparam logic [2:0] ACT_RESTART = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_TIE = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_LATCH1, OP_LATCH2, OP_DEC, OP_DIFF,
    OP_M1L, OP_M1H, OP_A1, OP_M2L, OP_M2H, OP_A2, OP_WRITE,
    OP_BQ_INIT, OP_BQ_STEP, OP_PTR_CAP, OP_PTR_INC,
    OP_MUL_E1, OP_MUL_E2, OP_SUM2,
    OP_RES_VAL, OP_RES_EMPTY, OP_RES_CODE, OP_RES_RESTART, OP_RES_CLEAR
  } dp_op_t;

  typedef enum logic [2:0] {
    RA_TOP, RA_PREV, RA_MID, RA_MID1, RA_LO, RA_PTR, RA_PTR1
  } rsel_t;

  typedef struct packed {
    dp_op_t     op;
    rsel_t      rsel;
    logic [1:0] res_st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       count_zero;
    logic       count_ge2;
    logic       count_full;
    logic       tie;
    logic       better;
    logic       useless;
    logic       lo_lt_hi;
    logic       ptr_adv;
    logic       not_better;
  } sts_t;

  typedef struct packed {
    logic maximize;
    logic slopes_increasing;
  } cfg_t;

endpackage

// ===== rtl/core/convex_hull_trick_engine.sv =====
// Top level of the convex hull trick engine: stream ports, register port, submodules.
// Depends on cht_pkg, cht_ctrl, cht_dp and cht_ram.
// Items arrive on the s_ side: s_tuser carries the action, s_tdata the line and
// the query abscissa. Every item gives exactly one result on the m_ side, with
// the value in m_tdata and the status code in m_tuser.
// Two registers on the APB port select maximum or minimum and the slope order;
// write them only while the block is idle.
// One item is worked on at a time; its result shows in the same cycle in which the
// next item can be accepted. Restarts, clears, unknown actions and empty hull queries
// go straight to the result. An add tests and pops the hull lines one at a time,
// paced by the one memory read port and the shared 33 by 33 multiplier that does
// the cross-multiplied test in four passes. A binary query makes about log2 of the
// line count probes, and a pointer query steps its pointer one line at a time.
// s_tready is high whenever no item is in work, also while a result
// still waits, and a stalled receiver holds the next result back until
// m_tready frees the output register. Reset empties the hull, zeroes the
// pointer, sets maximize to 0 and slopes_increasing to 1; the line memory is
// not cleared, since only entries below the line count are ever read.
module convex_hull_trick_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // slope[31:0], intercept[79:32], query_x[111:80]
  input  logic [2:0]   s_tuser,   // action[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // value[63:0]
  output logic [1:0]   m_tuser,   // status[1:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cht_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'b0, cfg.slopes_increasing} : {31'b0, cfg.maximize};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.maximize <= 1'b0;
      cfg.slopes_increasing <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        cfg.slopes_increasing <= pwdata[0];
      end else begin
        cfg.maximize <= pwdata[0];
      end
    end
  end

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cht_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ===== rtl/core/cht_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cht_ctrl.sv =====
// Controller state machine of the convex hull trick engine.
// Depends on cht_pkg; drives the datapath through cmd_t and reads sts_t.
module cht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output cht_pkg::cmd_t cmd,
  input  cht_pkg::sts_t sts
);
  import cht_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_TOP_LAT, S_TOP_CHK, S_POP, S_POP_L1, S_POP_L2, S_DIFF,
    S_M1L, S_M1H, S_A1, S_M2L, S_M2H, S_A2, S_CMP, S_WRITE,
    S_LOOP, S_EV_L1, S_EV_L2, S_EV_E1, S_EV_E2, S_EV_S, S_EV_CHK,
    S_FIN_L1, S_FIN_E1, S_FIN_E2, S_OUT
  } state_t;

  state_t     state, state_next;
  dp_op_t     res_op, res_op_next;
  logic [1:0] res_st, res_st_next;
  logic       slot_free;
  logic       is_bq;

  assign s_tready = (state == S_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign is_bq = (sts.act == ACT_BQUERY);

  always_comb begin
    state_next = state;
    res_op_next = res_op;
    res_st_next = res_st;
    cmd.op = OP_NONE;
    cmd.rsel = RA_TOP;
    cmd.res_st = res_st;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        res_op_next = OP_RES_CODE;
        res_st_next = ST_OK;
        case (sts.act)
          ACT_ADD: begin
            state_next = sts.count_zero ? S_WRITE : S_TOP_LAT;
          end
          ACT_BQUERY, ACT_PQUERY: begin
            if (sts.count_zero) begin
              res_op_next = OP_RES_EMPTY;
              state_next = S_OUT;
            end else begin
              cmd.op = is_bq ? OP_BQ_INIT : OP_PTR_CAP;
              state_next = S_LOOP;
            end
          end
          ACT_RESTART: begin
            res_op_next = OP_RES_RESTART;
            state_next = S_OUT;
          end
          ACT_CLEAR: begin
            res_op_next = OP_RES_CLEAR;
            state_next = S_OUT;
          end
          default: begin
            state_next = S_OUT;
          end
        endcase
      end
      S_TOP_LAT: begin
        cmd.op = OP_LATCH2;
        state_next = S_TOP_CHK;
      end
      S_TOP_CHK: begin
        if (sts.tie) begin
          if (sts.better) begin
            cmd.op = OP_DEC;
            state_next = S_POP;
          end else begin
            res_st_next = ST_TIE;
            state_next = S_OUT;
          end
        end else if (sts.count_full) begin
          res_st_next = ST_FULL;
          state_next = S_OUT;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.rsel = RA_PREV;
        state_next = sts.count_ge2 ? S_POP_L1 : S_WRITE;
      end
      S_POP_L1: begin
        cmd.op = OP_LATCH1;
        state_next = S_POP_L2;
      end
      S_POP_L2: begin
        cmd.op = OP_LATCH2;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op = OP_DIFF;
        state_next = S_M1L;
      end
      S_M1L: begin
        cmd.op = OP_M1L;
        state_next = S_M1H;
      end
      S_M1H: begin
        cmd.op = OP_M1H;
        state_next = S_A1;
      end
      S_A1: begin
        cmd.op = OP_A1;
        state_next = S_M2L;
      end
      S_M2L: begin
        cmd.op = OP_M2L;
        state_next = S_M2H;
      end
      S_M2H: begin
        cmd.op = OP_M2H;
        state_next = S_A2;
      end
      S_A2: begin
        cmd.op = OP_A2;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.useless) begin
          cmd.op = OP_DEC;
          state_next = S_POP;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.op = OP_WRITE;
        res_st_next = ST_OK;
        state_next = S_OUT;
      end
      S_LOOP: begin
        if (is_bq ? sts.lo_lt_hi : sts.ptr_adv) begin
          cmd.rsel = is_bq ? RA_MID : RA_PTR;
          state_next = S_EV_L1;
        end else begin
          cmd.rsel = is_bq ? RA_LO : RA_PTR;
          state_next = S_FIN_L1;
        end
      end
      S_EV_L1: begin
        cmd.op = OP_LATCH1;
        cmd.rsel = is_bq ? RA_MID1 : RA_PTR1;
        state_next = S_EV_L2;
      end
      S_EV_L2: begin
        cmd.op = OP_LATCH2;
        state_next = S_EV_E1;
      end
      S_EV_E1: begin
        cmd.op = OP_MUL_E1;
        state_next = S_EV_E2;
      end
      S_EV_E2: begin
        cmd.op = OP_MUL_E2;
        state_next = S_EV_S;
      end
      S_EV_S: begin
        cmd.op = OP_SUM2;
        state_next = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (is_bq) begin
          cmd.op = OP_BQ_STEP;
          state_next = S_LOOP;
        end else if (sts.not_better) begin
          cmd.op = OP_PTR_INC;
          state_next = S_LOOP;
        end else begin
          res_op_next = OP_RES_VAL;
          state_next = S_OUT;
        end
      end
      S_FIN_L1: begin
        cmd.op = OP_LATCH1;
        state_next = S_FIN_E1;
      end
      S_FIN_E1: begin
        cmd.op = OP_MUL_E1;
        state_next = S_FIN_E2;
      end
      S_FIN_E2: begin
        cmd.op = OP_MUL_E2;
        res_op_next = OP_RES_VAL;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.op = res_op;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      res_op <= OP_RES_CODE;
      res_st <= ST_OK;
    end else begin
      state <= state_next;
      res_op <= res_op_next;
      res_st <= res_st_next;
      if (state == S_OUT && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/cht_dp.sv =====
// Datapath of the convex hull trick engine: line store, counters, shared multiplier.
// Depends on cht_pkg and cht_ram; obeys cmd_t from cht_ctrl and reports sts_t.
module cht_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [111:0]                    s_tdata,
  input  logic [2:0]                      s_tuser,
  input  cht_pkg::cfg_t                   cfg,
  input  cht_pkg::cmd_t                   cmd,
  output cht_pkg::sts_t                   sts,
  output logic [cht_pkg::VALUE_W-1:0]     m_tdata,
  output logic [1:0]                      m_tuser
);
  import cht_pkg::*;

  logic [CNT_W-1:0]          count, cnt_m1, cnt_m2;
  logic [ADDR_W-1:0]         ptr, lo, hi, mid, raddr;
  logic [2:0]                act;
  logic signed [SLOPE_W-1:0] kn, k1, k2;
  logic signed [ICPT_W-1:0]  bn, b1, b2;
  logic signed [X_W-1:0]     x;
  logic signed [DB_W-1:0]    db_a, db_b;
  logic signed [DK_W-1:0]    dk_a, dk_b;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [CROSS_W-1:0] acc, p1, p2, prod_ext;
  logic signed [VALUE_W-1:0] vm, vn;
  logic [LINE_W-1:0]         rdata;
  logic                      we;
  logic                      stop;

  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);
  assign mid = lo + ((hi - lo) >> 1);
  assign we = (cmd.op == OP_WRITE);
  assign prod_ext = {{(CROSS_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign stop = cfg.maximize ? (vm >= vn) : (vm <= vn);

  always_comb begin
    case (cmd.rsel)
      RA_TOP:  raddr = cnt_m1[ADDR_W-1:0];
      RA_PREV: raddr = cnt_m2[ADDR_W-1:0];
      RA_MID:  raddr = mid;
      RA_MID1: raddr = mid + ADDR_W'(1);
      RA_LO:   raddr = lo;
      RA_PTR:  raddr = ptr;
      RA_PTR1: raddr = ptr + ADDR_W'(1);
      default: raddr = lo;
    endcase
  end

  cht_ram #(.WIDTH(LINE_W), .DEPTH(HULL_DEPTH)) u_lines (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({kn, bn}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.op)
      OP_M1L: begin
        mul_a = {1'b0, db_a[31:0]};
        mul_b = dk_a;
      end
      OP_M1H: begin
        mul_a = {{(MUL_W - 17){db_a[DB_W-1]}}, db_a[DB_W-1:32]};
        mul_b = dk_a;
      end
      OP_M2L: begin
        mul_a = {1'b0, db_b[31:0]};
        mul_b = dk_b;
      end
      OP_M2H: begin
        mul_a = {{(MUL_W - 17){db_b[DB_W-1]}}, db_b[DB_W-1:32]};
        mul_b = dk_b;
      end
      OP_MUL_E2: begin
        mul_a = {k2[SLOPE_W-1], k2};
        mul_b = {x[X_W-1], x};
      end
      default: begin
        mul_a = {k1[SLOPE_W-1], k1};
        mul_b = {x[X_W-1], x};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        act <= s_tuser;
        kn <= s_tdata[31:0];
        bn <= s_tdata[79:32];
        x <= s_tdata[111:80];
      end
      OP_LATCH1: begin
        k1 <= rdata[LINE_W-1:ICPT_W];
        b1 <= rdata[ICPT_W-1:0];
      end
      OP_LATCH2: begin
        k2 <= rdata[LINE_W-1:ICPT_W];
        b2 <= rdata[ICPT_W-1:0];
      end
      OP_DIFF: begin
        db_a <= {b2[ICPT_W-1], b2} - {b1[ICPT_W-1], b1};
        dk_a <= {k2[SLOPE_W-1], k2} - {kn[SLOPE_W-1], kn};
        db_b <= {bn[ICPT_W-1], bn} - {b2[ICPT_W-1], b2};
        dk_b <= {k1[SLOPE_W-1], k1} - {k2[SLOPE_W-1], k2};
      end
      OP_M1H, OP_M2H: acc <= prod_ext;
      OP_A1: p1 <= acc + (prod_ext <<< 32);
      OP_A2: p2 <= acc + (prod_ext <<< 32);
      OP_MUL_E2: vm <= prod[VALUE_W-1:0] + {{(VALUE_W - ICPT_W){b1[ICPT_W-1]}}, b1};
      OP_SUM2: vn <= prod[VALUE_W-1:0] + {{(VALUE_W - ICPT_W){b2[ICPT_W-1]}}, b2};
      OP_RES_VAL: begin
        m_tdata <= vm;
        m_tuser <= ST_OK;
      end
      OP_RES_EMPTY: begin
        m_tdata <= VALUE_MAX;
        m_tuser <= ST_EMPTY;
      end
      OP_RES_CODE, OP_RES_RESTART, OP_RES_CLEAR: begin
        m_tdata <= '0;
        m_tuser <= cmd.res_st;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr <= '0;
      lo <= '0;
      hi <= '0;
    end else begin
      case (cmd.op)
        OP_DEC: count <= cnt_m1;
        OP_WRITE: count <= count + CNT_W'(1);
        OP_BQ_INIT: begin
          lo <= '0;
          hi <= cnt_m1[ADDR_W-1:0];
        end
        OP_BQ_STEP: begin
          if (stop) begin
            hi <= mid;
          end else begin
            lo <= mid + ADDR_W'(1);
          end
        end
        OP_PTR_CAP: begin
          if (CNT_W'(ptr) >= count) begin
            ptr <= cnt_m1[ADDR_W-1:0];
          end
        end
        OP_PTR_INC: ptr <= ptr + ADDR_W'(1);
        OP_RES_RESTART: ptr <= '0;
        OP_RES_CLEAR: begin
          ptr <= '0;
          count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.act = act;
    sts.count_zero = (count == '0);
    sts.count_ge2 = (count >= CNT_W'(2));
    sts.count_full = (count == CNT_W'(HULL_DEPTH));
    sts.tie = (k2 == kn);
    sts.better = cfg.maximize ? (bn > b2) : (bn < b2);
    sts.useless = (cfg.maximize == cfg.slopes_increasing) ? (p1 >= p2) : (p1 <= p2);
    sts.lo_lt_hi = (lo < hi);
    sts.ptr_adv = (CNT_W'(ptr) + CNT_W'(1) < count);
    sts.not_better = cfg.maximize ? (vm <= vn) : (vm >= vn);
  end

endmodule

// ===== rtl/core/cht_chk.sv =====
// Port-level checker for the convex hull trick engine, bound to the top level.
// Depends on cht_pkg and convex_hull_trick_engine.
module cht_chk (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [1:0]   m_tuser
);
  import cht_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item shown right after reset");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> m_tdata == VALUE_MAX)
    else $error("empty hull result without largest value");

  a_drop_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_TIE) |-> m_tdata == '0)
    else $error("rejected add returned a nonzero value");

endmodule

bind convex_hull_trick_engine cht_chk u_chk (.*);

// ===== bench/convex_hull_trick_engine_tb.sv =====
// Self-checking testbench for convex_hull_trick_engine: directed and random items with
// an in-bench hull predictor. Depends on cht_pkg and the RTL of the block.
`timescale 1ns / 100ps

module convex_hull_trick_engine_tb;
  import cht_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  status;
  } hull_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;   // slope[31:0], intercept[79:32], query_x[111:80]
  logic [2:0]   s_tuser;   // action[2:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;   // value[63:0]
  logic [1:0]   m_tuser;   // status[1:0]
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  convex_hull_trick_engine DUT (.*);

  longint       hull_k [HULL_DEPTH];
  longint       hull_b [HULL_DEPTH];
  int           hull_n;
  int           scan_ptr;
  bit           cfg_max;
  bit           cfg_incr;
  hull_result_t pending_results[$];
  int           mismatches;
  int           cycles;
  int           send_idle_pct;
  int           recv_idle_pct;
  longint       last_k;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("convex_hull_trick_engine_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    hull_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%h status=%0d", m_tdata, m_tuser);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.value !== m_tdata || exp_r.status !== m_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     exp_r.value, exp_r.status, m_tdata, m_tuser);
        end
      end
    end
  end

  function automatic longint line_at(int i, longint x);
    return hull_k[i] * x + hull_b[i];
  endfunction

  function automatic bit top_dominated(longint k3, longint b3);
    logic signed [127:0] db21, dk23, db32, dk12, lhs, rhs;
    db21 = hull_b[hull_n-1] - hull_b[hull_n-2];
    dk23 = hull_k[hull_n-1] - k3;
    db32 = b3 - hull_b[hull_n-1];
    dk12 = hull_k[hull_n-2] - hull_k[hull_n-1];
    lhs = db21 * dk23;
    rhs = db32 * dk12;
    if (cfg_max == cfg_incr) return lhs >= rhs;
    return lhs <= rhs;
  endfunction

  function automatic bit not_better(longint v1, longint v2);
    return cfg_max ? (v1 <= v2) : (v1 >= v2);
  endfunction

  function automatic logic [1:0] hull_add(longint k, longint b);
    bit replace;
    replace = 0;
    if (hull_n > 0 && hull_k[hull_n-1] == k) begin
      if (!(cfg_max ? (b > hull_b[hull_n-1]) : (b < hull_b[hull_n-1]))) return ST_TIE;
      replace = 1;
    end
    if (!replace && hull_n >= HULL_DEPTH) return ST_FULL;
    if (replace) hull_n--;
    while (hull_n >= 2 && top_dominated(k, b)) hull_n--;
    hull_k[hull_n] = k;
    hull_b[hull_n] = b;
    hull_n++;
    return ST_OK;
  endfunction

  function automatic longint bsearch_value(longint x);
    int lo, hi, mid;
    longint vm, vn;
    lo = 0;
    hi = hull_n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      vm = line_at(mid, x);
      vn = line_at(mid + 1, x);
      if (cfg_max ? (vm >= vn) : (vm <= vn)) hi = mid;
      else lo = mid + 1;
    end
    return line_at(lo, x);
  endfunction

  function automatic longint scan_value(longint x);
    if (scan_ptr >= hull_n) scan_ptr = hull_n - 1;
    while (scan_ptr + 1 < hull_n && not_better(line_at(scan_ptr, x), line_at(scan_ptr + 1, x)))
      scan_ptr++;
    return line_at(scan_ptr, x);
  endfunction

  function automatic hull_result_t predict_hull(logic [2:0] act, longint k, longint b,
                                                longint x);
    hull_result_t r;
    r.value = '0;
    r.status = ST_OK;
    case (act)
      ACT_ADD: r.status = hull_add(k, b);
      ACT_BQUERY, ACT_PQUERY: begin
        if (hull_n == 0) begin
          r.value = VALUE_MAX;
          r.status = ST_EMPTY;
        end else begin
          r.value = (act == ACT_BQUERY) ? bsearch_value(x) : scan_value(x);
        end
      end
      ACT_RESTART: scan_ptr = 0;
      ACT_CLEAR: begin
        hull_n = 0;
        scan_ptr = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [2:0] act, longint k, longint b, longint x);
    hull_result_t exp_r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {x[31:0], b[47:0], k[31:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_r = predict_hull(act, k, b, x);
    pending_results.insert(pending_results.size(), exp_r);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, bit val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd0) cfg_max = val;
    else cfg_incr = val;
  endtask

  task automatic set_mode(bit maximize, bit increasing);
    drain_results();
    write_reg(3'd0, maximize);
    write_reg(3'd4, increasing);
    last_k = increasing ? -1000 : 1000;
  endtask

  task automatic test_empty_and_misc();
    send_item(ACT_BQUERY, 0, 0, 7);
    send_item(ACT_PQUERY, 0, 0, -7);
    send_item(ACT_RESTART, 0, 0, 0);
    send_item(3'd5, 32'h7fffffff, 5, 5);
    send_item(3'd6, -1, -1, -1);
    send_item(3'd7, 0, 0, 0);
    send_item(ACT_CLEAR, 0, 0, 0);
  endtask

  task automatic test_ties_and_extremes();
    send_item(ACT_ADD, 5, 10, 0);
    send_item(ACT_ADD, 5, 3, 0);
    send_item(ACT_ADD, 5, 20, 0);
    send_item(ACT_ADD, 5, 3, 0);
    send_item(ACT_ADD, 32'sh7fffffff, 48'sh7fffffffffff, 0);
    send_item(ACT_ADD, -64'sd2147483648, -64'sd140737488355328, 0);
    send_item(ACT_BQUERY, 0, 0, 32'sh7fffffff);
    send_item(ACT_BQUERY, 0, 0, -64'sd2147483648);
    send_item(ACT_PQUERY, 0, 0, -64'sd2147483648);
    send_item(ACT_PQUERY, 0, 0, 32'sh7fffffff);
    send_item(ACT_CLEAR, 0, 0, 0);
  endtask

  task automatic test_pointer_cap();
    for (int i = 0; i < 6; i++) send_item(ACT_ADD, 2 * i, -i * i, 0);
    send_item(ACT_PQUERY, 0, 0, 100);
    send_item(ACT_ADD, 1000, 5000, 0);
    send_item(ACT_PQUERY, 0, 0, 100);
    send_item(ACT_RESTART, 0, 0, 0);
    send_item(ACT_PQUERY, 0, 0, -100);
    send_item(ACT_CLEAR, 0, 0, 0);
  endtask

  task automatic test_full_hull();
    send_item(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < HULL_DEPTH; i++) send_item(ACT_ADD, 2 * i, -i * i, 0);
    send_item(ACT_ADD, 5000, 1, 0);
    send_item(ACT_ADD, 2 * (HULL_DEPTH - 1), 0, 0);
    send_item(ACT_BQUERY, 0, 0, 700);
    send_item(ACT_PQUERY, 0, 0, 1500);
    send_item(ACT_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    int     sel;
    longint k, b, x;
    logic [2:0] act;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      act = sel < 50 ? ACT_ADD : sel < 70 ? ACT_BQUERY : sel < 88 ? ACT_PQUERY :
            sel < 92 ? ACT_RESTART : sel < 96 ? ACT_CLEAR : 3'($urandom_range(5, 7));
      sel = $urandom_range(99);
      if (sel < 10) k = longint'($signed($urandom()));
      else if (sel < 20) k = last_k;
      else k = last_k + (cfg_incr ? 1 : -1) * longint'($urandom_range(1, 1000));
      if (k > 2147483647 || k < -2147483648) k = longint'($signed($urandom()));
      if (act == ACT_ADD) last_k = k;
      if ($urandom_range(9) < 7) b = longint'($urandom_range(0, 2000000)) - 1000000;
      else b = {{16{1'b0}}, 16'($urandom()), 32'($urandom())} - 64'sd140737488355328;
      if ($urandom_range(9) < 7) x = longint'($urandom_range(0, 10000)) - 5000;
      else x = longint'($signed($urandom()));
      send_item(act, k, b, x);
      if (n == count / 2 && count > 100) drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hull_n = 0;
    scan_ptr = 0;
    cfg_max = 0;
    cfg_incr = 1;
    last_k = -1000;
    send_idle_pct = 16;
    recv_idle_pct = 84;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_misc();
    test_ties_and_extremes();
    test_pointer_cap();
    test_random(150, 16, 84);
    set_mode(1, 1);
    test_full_hull();
    test_random(150, 84, 16);
    set_mode(1, 0);
    test_ties_and_extremes();
    test_random(100, 0, 0);
    set_mode(0, 0);
    test_random(100, 0, 0);
    set_mode(0, 1);
    test_random(50, 0, 0);
    drain_results();
    if (mismatches == 0) $display("convex_hull_trick_engine_tb: clean");
    else $display("convex_hull_trick_engine_tb: errors");
    $finish;
  end

endmodule
